FILE: rtl/core/bpq_pkg.sv
// shared constants and types for the bucket priority queue
package bpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int LEVELS      = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int LEVEL_W = $clog2(LEVELS);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int PRI_W   = 4;
    localparam int WORD_W  = SLOT_W + VALUE_WIDTH;

    // priority numbers at or above this are never stored
    localparam logic [PRI_W:0] LEVEL_LIMIT = (PRI_W + 1)'(LEVELS);

    // register index carried in paddr[2]
    localparam logic CFG_IDX_MAX_PRI = 1'b0;
    localparam logic [PRI_W-1:0] MAX_PRI_RESET = PRI_W'(15);

    // request kinds on the input tuser
    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // successor entry of a slot: next slot of the same level and its value
    typedef struct packed {
        logic [SLOT_W-1:0]      next_slot;
        logic [VALUE_WIDTH-1:0] next_val;
    } link_word_t;

endpackage

FILE: rtl/core/bpq_ram.sv
// generic single-port-write, registered-read ram
module bpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bucket_priority_queue_core.sv
// bucket priority queue: one linked fifo per priority level, level 0 served first
// latency: a request accepted at one edge has its result on m_tdata after that edge
// throughput: one request per cycle unless stalled; the front slot's successor is read each cycle
// reset: async active-low, clears levels, free map, count and the output stage;
// max_priority returns to 15, the link ram is not cleared and needs no clearing pass
module bucket_priority_queue_core
    import bpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_value[31:0], item_priority[35:32], zero fill
    input  logic [0:0]  s_tuser,   // req_type
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // removed_value, removed_priority, head_value,
                                   // head_priority, item_count, is_empty, error, zero fill
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    function automatic logic [SLOT_W-1:0] low_slot(input logic [CAPACITY-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [LEVEL_W-1:0] low_level(input logic [LEVELS-1:0] v);
        logic [LEVEL_W-1:0] idx;
        idx = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = LEVEL_W'(i);
            end
        end
        return idx;
    endfunction

    // state
    logic [PRI_W-1:0]       max_pri_reg;
    logic [CAPACITY-1:0]    free_reg,     free_next;
    logic [COUNT_W-1:0]     count_reg,    count_next;
    logic [LEVELS-1:0]      nonempty_reg, nonempty_next;
    logic [SLOT_W-1:0]      head_reg     [LEVELS];
    logic [SLOT_W-1:0]      head_next    [LEVELS];
    logic [SLOT_W-1:0]      tail_reg     [LEVELS];
    logic [SLOT_W-1:0]      tail_next    [LEVELS];
    logic [VALUE_WIDTH-1:0] head_val_reg [LEVELS];
    logic [VALUE_WIDTH-1:0] head_val_next[LEVELS];

    // copy of the lowest non-empty level
    logic [LEVEL_W-1:0]     front_lv_reg,   front_lv_next;
    logic [SLOT_W-1:0]      front_slot_reg, front_slot_next;
    logic [SLOT_W-1:0]      front_tail_reg, front_tail_next;
    logic [VALUE_WIDTH-1:0] front_val_reg,  front_val_next;

    // successor ram and write bypass
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    link_word_t        ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              byp_reg,      byp_next;
    link_word_t        byp_data_reg;
    link_word_t        succ;

    // output stage
    logic        m_tvalid_reg, m_tvalid_next;
    logic [87:0] m_tdata_reg,  m_tdata_next;

    // request decode
    logic                   accept;
    logic                   req;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [PRI_W-1:0]       in_pri;
    logic [LEVEL_W-1:0]     in_lv;
    logic                   q_empty;
    logic                   free_any;
    logic [SLOT_W-1:0]      free_idx;
    logic [LEVELS-1:0]      others;
    logic                   after_any;
    logic [LEVEL_W-1:0]     after_lv;
    logic [LEVEL_W-1:0]     rd_lv;
    logic [SLOT_W-1:0]      rd_head;
    logic [SLOT_W-1:0]      rd_tail;
    logic [VALUE_WIDTH-1:0] rd_val;

    // result fields
    logic [VALUE_WIDTH-1:0] rem_val;
    logic [PRI_W-1:0]       rem_pri;
    logic [VALUE_WIDTH-1:0] out_head_val;
    logic [PRI_W-1:0]       out_head_pri;
    logic                   err;

    assign accept   = s_tvalid && s_tready;
    assign req      = s_tuser[0];
    assign in_val   = s_tdata[VALUE_WIDTH-1:0];
    assign in_pri   = s_tdata[VALUE_WIDTH+PRI_W-1:VALUE_WIDTH];
    assign in_lv    = in_pri[LEVEL_W-1:0];
    assign q_empty  = (nonempty_reg == '0);
    assign free_any = (free_reg != '0);
    assign free_idx = low_slot(free_reg);

    // next front level once the current front level drains
    always_comb
    begin
        others               = nonempty_reg;
        others[front_lv_reg] = 1'b0;
    end
    assign after_any = (others != '0);
    assign after_lv  = low_level(others);

    // one level-table read per request
    assign rd_lv   = (req == REQ_ENQUEUE) ? in_lv : after_lv;
    assign rd_head = head_reg[rd_lv];
    assign rd_tail = tail_reg[rd_lv];
    assign rd_val  = head_val_reg[rd_lv];

    assign succ = byp_reg ? byp_data_reg : link_word_t'(ram_rdata);

    always_comb
    begin
        free_next       = free_reg;
        count_next      = count_reg;
        nonempty_next   = nonempty_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_val_next   = head_val_reg;
        front_lv_next   = front_lv_reg;
        front_slot_next = front_slot_reg;
        front_tail_next = front_tail_reg;
        front_val_next  = front_val_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_tail;
        ram_wdata       = '{next_slot: free_idx, next_val: in_val};
        rem_val         = '0;
        rem_pri         = '0;
        err             = 1'b0;

        if (accept)
        begin
            if (req == REQ_ENQUEUE)
            begin
                if (in_pri > max_pri_reg || {1'b0, in_pri} >= LEVEL_LIMIT || !free_any)
                begin
                    err = 1'b1;
                end
                else
                begin
                    free_next[free_idx] = 1'b0;
                    count_next          = count_reg + 1'b1;
                    if (nonempty_reg[in_lv])
                    begin
                        // append behind the current tail
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        head_next[in_lv]     = free_idx;
                        head_val_next[in_lv] = in_val;
                        nonempty_next[in_lv] = 1'b1;
                    end
                    tail_next[in_lv] = free_idx;
                    if (q_empty || in_lv < front_lv_reg)
                    begin
                        front_lv_next   = in_lv;
                        front_slot_next = free_idx;
                        front_tail_next = free_idx;
                        front_val_next  = in_val;
                    end
                    else if (in_lv == front_lv_reg)
                    begin
                        front_tail_next = free_idx;
                    end
                end
            end
            else
            begin
                if (q_empty)
                begin
                    err = 1'b1;
                end
                else
                begin
                    rem_val                   = front_val_reg;
                    rem_pri                   = PRI_W'(front_lv_reg);
                    free_next[front_slot_reg] = 1'b1;
                    count_next                = count_reg - 1'b1;
                    if (front_slot_reg != front_tail_reg)
                    begin
                        head_next[front_lv_reg]     = succ.next_slot;
                        head_val_next[front_lv_reg] = succ.next_val;
                        front_slot_next             = succ.next_slot;
                        front_val_next              = succ.next_val;
                    end
                    else
                    begin
                        nonempty_next[front_lv_reg] = 1'b0;
                        if (after_any)
                        begin
                            front_lv_next   = after_lv;
                            front_slot_next = rd_head;
                            front_tail_next = rd_tail;
                            front_val_next  = rd_val;
                        end
                    end
                end
            end
        end

        if (nonempty_next != '0)
        begin
            out_head_val = front_val_next;
            out_head_pri = PRI_W'(front_lv_next);
        end
        else
        begin
            out_head_val = '0;
            out_head_pri = '0;
        end

        // a write landing on the slot being read must be forwarded
        byp_next = ram_we && (ram_waddr == front_slot_next);
    end

    bpq_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_link_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(front_slot_next),
        .rdata(ram_rdata)
    );

    // output stage
    assign s_tready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (s_tready)
        begin
            m_tvalid_next = accept;
            m_tdata_next  = {7'b0, err, (count_next == '0), count_next,
                             out_head_pri, out_head_val, rem_pri, rem_val};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pri_reg    <= MAX_PRI_RESET;
            free_reg       <= '1;
            count_reg      <= '0;
            nonempty_reg   <= '0;
            front_lv_reg   <= '0;
            front_slot_reg <= '0;
            front_tail_reg <= '0;
            byp_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_MAX_PRI)
            begin
                max_pri_reg <= pwdata[PRI_W-1:0];
            end
            free_reg       <= free_next;
            count_reg      <= count_next;
            nonempty_reg   <= nonempty_next;
            front_lv_reg   <= front_lv_next;
            front_slot_reg <= front_slot_next;
            front_tail_reg <= front_tail_next;
            byp_reg        <= byp_next;
            m_tvalid_reg   <= m_tvalid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_val_reg  <= head_val_next;
        front_val_reg <= front_val_next;
        byp_data_reg  <= ram_wdata;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == CFG_IDX_MAX_PRI) ? 32'(max_pri_reg) : 32'b0;

`ifndef ASSERT_OFF
    a_count_matches_free: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(~free_reg) == 32'(count_reg))
        else $error("stored count disagrees with free-slot map");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (nonempty_reg == '0))
        else $error("level flags disagree with stored count");

    a_front_is_lowest: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg != '0) |-> (front_lv_reg == low_level(nonempty_reg)))
        else $error("front copy is not the lowest non-empty level");

    a_front_matches_table: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg != '0) |-> (head_reg[front_lv_reg] == front_slot_reg &&
                                  tail_reg[front_lv_reg] == front_tail_reg))
        else $error("front copy out of step with level tables");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid_reg)
        else $error("input stalled with an empty output stage");
`endif

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the bucket priority queue core
`timescale 1ns / 1ps

module tb_top
    import bpq_pkg::*;
();

    localparam int LONG_HOLD   = 100;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;

    typedef struct {
        logic [31:0] removed_value;
        logic [3:0]  removed_priority;
        logic [31:0] head_value;
        logic [3:0]  head_priority;
        logic [6:0]  item_count;
        logic        is_empty;
        logic        error;
    } reply_t;

    // per-level fifos mirror the block; slot allocation does not show at the outputs
    class queue_predictor;
        logic [VALUE_WIDTH-1:0] level_fifo [LEVELS][$];
        logic [PRI_W-1:0]       max_pri;
        int unsigned            stored;
        reply_t                 expected_replies[$];
        int                     fail_count;

        function new();
            max_pri    = MAX_PRI_RESET;
            stored     = 0;
            fail_count = 0;
        endfunction

        function void set_max_priority(logic [PRI_W-1:0] v);
            max_pri = v;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_request(logic req, logic [31:0] val, logic [3:0] pri);
            reply_t r;
            int lv;
            r.removed_value    = '0;
            r.removed_priority = '0;
            r.error            = 1'b0;
            if (req == REQ_ENQUEUE)
            begin
                if (pri > max_pri || pri >= LEVELS || stored >= CAPACITY)
                    r.error = 1'b1;
                else
                begin
                    level_fifo[pri].push_back(val);
                    stored++;
                end
            end
            else
            begin
                lv = LEVELS;
                for (int i = LEVELS - 1; i >= 0; i--)
                    if (level_fifo[i].size() != 0)
                        lv = i;
                if (lv == LEVELS)
                    r.error = 1'b1;
                else
                begin
                    r.removed_value    = level_fifo[lv].pop_front();
                    r.removed_priority = 4'(lv);
                    stored--;
                end
            end
            r.head_value    = '0;
            r.head_priority = '0;
            for (int i = LEVELS - 1; i >= 0; i--)
                if (level_fifo[i].size() != 0)
                begin
                    r.head_value    = level_fifo[i][0];
                    r.head_priority = 4'(i);
                end
            r.item_count = 7'(stored);
            r.is_empty   = (stored == 0);
            expected_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_reply(logic [87:0] word);
            reply_t r;
            if (expected_replies.size() == 0)
            begin
                $error("reply with nothing outstanding: %h", word);
                fail_count++;
                return;
            end
            r = expected_replies.pop_front();
            compare_field("removed_value", r.removed_value, word[31:0]);
            compare_field("removed_priority", 32'(r.removed_priority), 32'(word[35:32]));
            compare_field("head_value", r.head_value, word[67:36]);
            compare_field("head_priority", 32'(r.head_priority), 32'(word[71:68]));
            compare_field("item_count", 32'(r.item_count), 32'(word[78:72]));
            compare_field("is_empty", 32'(r.is_empty), 32'(word[79]));
            compare_field("error", 32'(r.error), 32'(word[80]));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // item_value[31:0], item_priority[35:32], zero fill
    logic [0:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // removed_value, removed_priority, head_value,
                            // head_priority, item_count, is_empty, error, zero fill
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    queue_predictor board = new();
    logic [3:0]     cur_limit;
    bit             calm;
    bit             hold_request;
    int             stall_cycles;

    bucket_priority_queue_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_request(input logic req, input logic [31:0] val,
                                input logic [3:0] pri);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, pri, val};
        do @(posedge clk); while (!s_tready);
        board.note_request(req, val, pri);
    endtask

    task automatic idle_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // drops valid and waits until every outstanding reply has been checked
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_max_pri(input logic [3:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {CFG_IDX_MAX_PRI, 2'b00};
        pwdata  <= {28'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_max_priority(v);
        cur_limit = v;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly legal levels, now and then any level so that out-of-range ones appear
    function automatic logic [3:0] pick_priority(input logic [3:0] limit);
        if ($urandom_range(0, 6) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, limit));
    endfunction

    // result sink: random back-pressure plus one long hold-off on request
    initial
    begin : reply_sink
        int   idle_left;
        int   hold_left;
        logic ready_next;
        idle_left = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_reply(m_tdata);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (calm)
                ready_next = 1'b1;
            else if (idle_left > 0)
            begin
                idle_left--;
                ready_next = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                idle_left  = $urandom_range(0, 3);
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [3:0] limits [PHASES];
        int         enq_bias;
        logic       req;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        hold_request = 1'b0;
        cur_limit    = MAX_PRI_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dequeue, value extremes, fifo order within and across levels
        write_max_pri(4'd15);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_ENQUEUE, 32'hFFFF_FFFF, 4'd15);
        send_request(REQ_ENQUEUE, 32'h0, 4'd0);
        send_request(REQ_ENQUEUE, 32'hA5A5_A5A5, 4'd0);
        send_request(REQ_ENQUEUE, 32'h1234_5678, 4'd7);
        send_request(REQ_DEQUEUE, 32'hFFFF_FFFF, 4'd15);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);

        // lowest limit: only level 0 is accepted
        wait_drained();
        write_max_pri(4'd0);
        send_request(REQ_ENQUEUE, 32'h5A5A_5A5A, 4'd1);
        send_request(REQ_ENQUEUE, 32'h0000_0001, 4'd0);
        send_request(REQ_ENQUEUE, 32'h8000_0000, 4'd15);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);

        // limit lowered while higher levels still hold items
        wait_drained();
        write_max_pri(4'd15);
        send_request(REQ_ENQUEUE, 32'hCAFE_0001, 4'd12);
        send_request(REQ_ENQUEUE, 32'hCAFE_0002, 4'd12);
        wait_drained();
        write_max_pri(4'd3);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_ENQUEUE, 32'hCAFE_0003, 4'd12);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);
        send_request(REQ_DEQUEUE, 32'h0, 4'd0);

        limits = '{4'd15, 4'd0, 4'd7, 4'd15, 4'($urandom_range(0, 15)), 4'd3, 4'd15, 4'd15};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            write_max_pri(limits[ph]);
            calm     = (ph == PHASES - 1);
            // even phases push towards full storage, odd ones drain it
            enq_bias = (ph % 2 == 0) ? 75 : 35;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == 40)
                    hold_request = 1'b1;
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    wait_drained();
                req = ($urandom_range(0, 99) < enq_bias) ? REQ_ENQUEUE : REQ_DEQUEUE;
                send_request(req, random_value(), pick_priority(cur_limit));
                if (!calm && $urandom_range(0, 4) == 0)
                    idle_sender($urandom_range(1, 4));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bpq_pkg.sv
rtl/core/bpq_ram.sv
rtl/core/bucket_priority_queue_core.sv
tb/tb_top.sv
